// ----- rtl/seeded_multi_algorithm_prng_unit_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the seeded multi-algorithm PRNG unit
// Short forms for clocked implication checks; each expects clk_i and rst_ni
// in the module that uses it.
// -----------------------------------------------------------------------------
`ifndef SEEDED_MULTI_ALGORITHM_PRNG_UNIT_MACROS_SVH
`define SEEDED_MULTI_ALGORITHM_PRNG_UNIT_MACROS_SVH

// Same-cycle implication.
`define SMPRNG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMPRNG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smprng_pkg.sv -----
// -----------------------------------------------------------------------------
// smprng_pkg
// Shared widths, constants, codes and controller/datapath interface types.
// -----------------------------------------------------------------------------
package smprng_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned AlgW    = 2;
  localparam int unsigned CntW    = 7;
  localparam int unsigned XoDepth = 4;
  localparam int unsigned XoIdxW  = 2;

  localparam int unsigned WarmupRoundsDef = 64;

  localparam logic [DataW-1:0] SmGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [DataW-1:0] SmMul1  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [DataW-1:0] SmMul2  = 64'h94d0_49bb_1331_11eb;
  localparam logic [DataW-1:0] RaKey1  = 64'hcf14_f4eb_c546_2216;
  localparam logic [DataW-1:0] RaKey2  = 64'h9576_080c_75ec_fc58;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_NEXT = 1'b1
  } opcode_e;

  typedef enum logic [AlgW-1:0] {
    ALG_SPLITMIX = 2'd0,
    ALG_XOSHIRO  = 2'd1,
    ALG_ROTADD   = 2'd2
  } alg_sel_e;

  localparam logic [AlgW-1:0] AlgResetVal = ALG_XOSHIRO;

  typedef enum logic [1:0] {
    RES_SM   = 2'd0,
    RES_XO   = 2'd1,
    RES_RA   = 2'd2,
    RES_ZERO = 2'd3
  } res_src_e;

  typedef struct packed {
    logic     seed_load;
    logic     sm_add;
    logic     mul_ll;
    logic     mul_hl;
    logic     mul_lh;
    logic     mul_k2;
    logic     mix27;
    logic     sm_fill;
    logic     xo_step;
    logic     ra_step;
    logic     cnt_inc;
    logic     res_load;
    res_src_e res_src;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [AlgW-1:0] alg;
    logic            fill_last;
    logic            warm_done;
  } dp_status_t;

endpackage

// ----- rtl/smprng_dp.sv -----
// -----------------------------------------------------------------------------
// smprng_dp
// Generator state, shared 32x32 multiplier, result and output registers.
// -----------------------------------------------------------------------------
module smprng_dp import smprng_pkg::*; #(
  parameter int unsigned WARMUP_ROUNDS = WarmupRoundsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AlgW-1:0]  cfg_wdata_i,
  input  logic [DataW-1:0] seed_value_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  output logic [DataW-1:0] random_value_o
);

  localparam logic [CntW-1:0]   WarmupLast = CntW'(WARMUP_ROUNDS);
  localparam logic [XoIdxW-1:0] XoLast     = XoIdxW'(XoDepth - 1);

  logic [AlgW-1:0]   alg_q;
  logic [DataW-1:0]  ctr_q;
  logic [DataW-1:0]  xo_q [XoDepth];
  logic [DataW-1:0]  ra0_q, ra1_q;
  logic [CntW-1:0]   cnt_q;
  logic [XoIdxW-1:0] xidx_q;
  logic [DataW-1:0]  z_q, acc_q, res_q, rnd_q;

  logic [DataW-1:0] ctr_sum;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [DataW-1:0] mul_k, prod, sm_out;
  logic [HalfW-1:0] acc_hi_sum;
  logic [DataW-1:0] xo_sum, xo_out, xo_t, xo_n0, xo_n1, xo_n2, xo_n3;
  logic [DataW-1:0] ra_x1, ra_x2, ra0_n, ra1_n;
  logic [DataW-1:0] res_d;

  // SplitMix64 counter advance and first xor-shift.
  assign ctr_sum = ctr_q + SmGamma;

  // One 32x32 multiplier; a 64-bit product modulo 2^64 takes three passes.
  assign mul_k      = cmd_i.mul_k2 ? SmMul2 : SmMul1;
  assign mul_a      = cmd_i.mul_hl ? z_q[DataW-1:HalfW] : z_q[HalfW-1:0];
  assign mul_b      = cmd_i.mul_lh ? mul_k[DataW-1:HalfW] : mul_k[HalfW-1:0];
  assign prod       = DataW'(mul_a) * DataW'(mul_b);
  assign acc_hi_sum = acc_q[DataW-1:HalfW] + prod[HalfW-1:0];
  assign sm_out     = acc_q ^ (acc_q >> 31);

  // xoshiro256++ step.
  assign xo_sum = xo_q[0] + xo_q[3];
  assign xo_out = {xo_sum[40:0], xo_sum[63:41]} + xo_q[0];
  assign xo_t   = xo_q[1] << 17;
  assign xo_n2  = xo_q[2] ^ xo_q[0];
  assign xo_n3  = xo_q[3] ^ xo_q[1];
  assign xo_n1  = xo_q[1] ^ xo_n2;
  assign xo_n0  = xo_q[0] ^ xo_n3;

  // Rotate-add step.
  assign ra_x1 = ra1_q ^ RaKey1;
  assign ra_x2 = ra0_q ^ RaKey2;
  assign ra0_n = ra0_q + {ra_x1[0], ra_x1[63:1]};
  assign ra1_n = ra1_q + {ra_x2[8:0], ra_x2[63:9]};

  always_comb begin
    unique case (cmd_i.res_src)
      RES_SM:  res_d = sm_out;
      RES_XO:  res_d = xo_out;
      RES_RA:  res_d = ra1_n;
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q  <= AlgResetVal;
      ctr_q  <= '0;
      ra0_q  <= '0;
      ra1_q  <= '0;
      cnt_q  <= '0;
      xidx_q <= '0;
      for (int i = 0; i < XoDepth; i++) begin
        xo_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        alg_q <= cfg_wdata_i;
      end
      if (cmd_i.seed_load) begin
        ctr_q  <= seed_value_i;
        ra0_q  <= seed_value_i;
        ra1_q  <= seed_value_i;
        cnt_q  <= '0;
        xidx_q <= '0;
      end else begin
        if (cmd_i.sm_add) begin
          ctr_q <= ctr_sum;
        end
        if (cmd_i.ra_step) begin
          ra0_q <= ra0_n;
          ra1_q <= ra1_n;
        end
        if (cmd_i.cnt_inc) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmd_i.sm_fill) begin
          xo_q[xidx_q] <= sm_out;
          xidx_q       <= xidx_q + 1'b1;
        end else if (cmd_i.xo_step) begin
          xo_q[0] <= xo_n0;
          xo_q[1] <= xo_n1;
          xo_q[2] <= xo_n2 ^ xo_t;
          xo_q[3] <= {xo_n3[18:0], xo_n3[63:19]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sm_add) begin
      z_q <= ctr_sum ^ (ctr_sum >> 30);
    end else if (cmd_i.mix27) begin
      z_q <= acc_q ^ (acc_q >> 27);
    end
    if (cmd_i.mul_ll) begin
      acc_q <= prod;
    end else if (cmd_i.mul_hl || cmd_i.mul_lh) begin
      acc_q[DataW-1:HalfW] <= acc_hi_sum;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      rnd_q <= res_q;
    end
  end

  assign status_o.alg       = alg_q;
  assign status_o.fill_last = (xidx_q == XoLast);
  assign status_o.warm_done = (cnt_q == WarmupLast);
  assign random_value_o     = rnd_q;

endmodule

// ----- rtl/smprng_ctrl.sv -----
// -----------------------------------------------------------------------------
// smprng_ctrl
// Sequencer for seeding, SplitMix64 multiply passes and result hand-off.
// -----------------------------------------------------------------------------
`include "seeded_multi_algorithm_prng_unit_macros.svh"

module smprng_ctrl import smprng_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       opcode_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_SM_ADD = 12'b0000_0000_0010,
    ST_MA0    = 12'b0000_0000_0100,
    ST_MA1    = 12'b0000_0000_1000,
    ST_MA2    = 12'b0000_0001_0000,
    ST_MIX    = 12'b0000_0010_0000,
    ST_MB0    = 12'b0000_0100_0000,
    ST_MB1    = 12'b0000_1000_0000,
    ST_MB2    = 12'b0001_0000_0000,
    ST_FIN    = 12'b0010_0000_0000,
    ST_WARM   = 12'b0100_0000_0000,
    ST_EMIT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   seeding_q, seeding_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    seeding_d = seeding_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_SEED) begin
            cmd_o.seed_load = 1'b1;
            seeding_d       = 1'b1;
            state_d         = ST_SM_ADD;
          end else begin
            seeding_d = 1'b0;
            unique case (status_i.alg)
              ALG_SPLITMIX: begin
                state_d = ST_SM_ADD;
              end
              ALG_XOSHIRO: begin
                cmd_o.xo_step  = 1'b1;
                cmd_o.res_load = 1'b1;
                cmd_o.res_src  = RES_XO;
                state_d        = ST_EMIT;
              end
              ALG_ROTADD: begin
                cmd_o.ra_step  = 1'b1;
                cmd_o.res_load = 1'b1;
                cmd_o.res_src  = RES_RA;
                state_d        = ST_EMIT;
              end
              default: begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_src  = RES_ZERO;
                state_d        = ST_EMIT;
              end
            endcase
          end
        end
      end
      ST_SM_ADD: begin
        cmd_o.sm_add = 1'b1;
        state_d      = ST_MA0;
      end
      ST_MA0: begin
        cmd_o.mul_ll = 1'b1;
        state_d      = ST_MA1;
      end
      ST_MA1: begin
        cmd_o.mul_hl = 1'b1;
        state_d      = ST_MA2;
      end
      ST_MA2: begin
        cmd_o.mul_lh = 1'b1;
        state_d      = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix27 = 1'b1;
        state_d     = ST_MB0;
      end
      ST_MB0: begin
        cmd_o.mul_ll = 1'b1;
        cmd_o.mul_k2 = 1'b1;
        state_d      = ST_MB1;
      end
      ST_MB1: begin
        cmd_o.mul_hl = 1'b1;
        cmd_o.mul_k2 = 1'b1;
        state_d      = ST_MB2;
      end
      ST_MB2: begin
        cmd_o.mul_lh = 1'b1;
        cmd_o.mul_k2 = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (seeding_q) begin
          cmd_o.sm_fill = 1'b1;
          state_d       = status_i.fill_last ? ST_WARM : ST_SM_ADD;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = RES_SM;
          state_d        = ST_EMIT;
        end
      end
      ST_WARM: begin
        if (status_i.warm_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.ra_step = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seeding_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeding_q   <= seeding_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `SMPRNG_ASSERT_IMP(a_out_no_overwrite, cmd_o.out_load, !out_valid_q || !out_stall_i, "output register overwritten while an item waits")
  `SMPRNG_ASSERT_NXT(a_warm_holds, state_q == ST_WARM && !status_i.warm_done, state_q == ST_WARM, "warm-up left before its round count")
  `SMPRNG_ASSERT_NXT(a_seed_starts, in_valid_i && !in_stall_o && opcode_i == OP_SEED, seeding_q && state_q == ST_SM_ADD, "seed item did not start the fill sequence")
  `SMPRNG_ASSERT_IMP(a_no_seed_result, cmd_o.res_load && state_q != ST_IDLE, !seeding_q, "seed item produced a result")

endmodule

// ----- rtl/seeded_multi_algorithm_prng_unit.sv -----
// -----------------------------------------------------------------------------
// seeded_multi_algorithm_prng_unit
// 64-bit PRNG with SplitMix64, xoshiro256++ and rotate-add generators.
// -----------------------------------------------------------------------------
// Takes one item at a time. A next item with xoshiro256++, the rotate-add
// generator or the unused selector code goes through the result register
// into the output register; those steps are combinational adds, xors and
// rotates. In a SplitMix64 next item, its two 64-bit multiplies each run as
// three passes through one shared 32x32 multiplier, with an xor-shift step
// between them. Either kind of next item takes longer while an earlier
// result still waits in the output register. A seed item gives no result and
// holds off the input until four SplitMix64 outputs have filled the
// xoshiro256++ words and the rotate-add generator has run WARMUP_ROUNDS
// warm-up rounds, one per cycle, after which the block returns to idle. The
// result sits in an output register, so the next item is accepted while an
// earlier result still waits to be taken.
// Seed the block before asking for numbers; from reset the xoshiro256++ words
// are all zero and that generator returns zero.
// -----------------------------------------------------------------------------
module seeded_multi_algorithm_prng_unit import smprng_pkg::*; #(
  parameter int unsigned WARMUP_ROUNDS = WarmupRoundsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: algorithm select register.
  input  logic             cfg_we_i,
  input  logic [AlgW-1:0]  cfg_wdata_i,
  // Input item channel.
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [DataW-1:0] seed_value_i,
  // Result item channel.
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] random_value_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller sequences each item; the datapath holds all generator
  // state and does the arithmetic it is told to do.
  smprng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smprng_dp #(
    .WARMUP_ROUNDS(WARMUP_ROUNDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .seed_value_i  (seed_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .random_value_o(random_value_o)
  );

endmodule

// ----- dv/smprng_checker.sv -----
// -----------------------------------------------------------------------------
// smprng_checker
// Watches both item channels and the select register of the PRNG unit, keeps
// its own copy of the three generators and compares every returned number.
// -----------------------------------------------------------------------------
module smprng_checker
  import smprng_pkg::*;
#(
  parameter int unsigned WarmupRounds = WarmupRoundsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AlgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             opcode_i,
  input  logic [DataW-1:0] seed_value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [DataW-1:0] random_value_i,
  output int               mismatch_count_o,
  output int               expected_left_o,
  output int               results_checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [AlgW-1:0]  alg_q;
  logic [DataW-1:0] sm_counter;
  logic [DataW-1:0] xo_words [XoDepth];
  logic [DataW-1:0] ra_words [2];
  logic [DataW-1:0] expected_randoms [$];
  logic [DataW-1:0] oldest_expected;
  int               mismatches;
  int               checked;

  function automatic logic [DataW-1:0] rotl64(input logic [DataW-1:0] v,
                                              input int unsigned k);
    return (v << k) | (v >> (DataW - k));
  endfunction

  function automatic logic [DataW-1:0] rotr64(input logic [DataW-1:0] v,
                                              input int unsigned k);
    return (v >> k) | (v << (DataW - k));
  endfunction

  function automatic logic [DataW-1:0] splitmix_step();
    logic [DataW-1:0] z;
    sm_counter = sm_counter + SmGamma;
    z = sm_counter;
    z = (z ^ (z >> 30)) * SmMul1;
    z = (z ^ (z >> 27)) * SmMul2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [DataW-1:0] xoshiro_step();
    logic [DataW-1:0] result;
    logic [DataW-1:0] t;
    result = rotl64(xo_words[0] + xo_words[3], 23) + xo_words[0];
    t = xo_words[1] << 17;
    xo_words[2] = xo_words[2] ^ xo_words[0];
    xo_words[3] = xo_words[3] ^ xo_words[1];
    xo_words[1] = xo_words[1] ^ xo_words[2];
    xo_words[0] = xo_words[0] ^ xo_words[3];
    xo_words[2] = xo_words[2] ^ t;
    xo_words[3] = rotl64(xo_words[3], 45);
    return result;
  endfunction

  function automatic logic [DataW-1:0] rotadd_step();
    logic [DataW-1:0] old0;
    old0 = ra_words[0];
    ra_words[0] = ra_words[0] + rotr64(ra_words[1] ^ RaKey1, 1);
    ra_words[1] = ra_words[1] + rotr64(old0 ^ RaKey2, 9);
    return ra_words[1];
  endfunction

  // A seed reloads all three generators; the warm-up count is kept to 7 bits
  // like the warm-up counter in the datapath.
  function automatic void reseed_all(input logic [DataW-1:0] seed);
    sm_counter = seed;
    for (int i = 0; i < XoDepth; i++) begin
      xo_words[i] = splitmix_step();
    end
    ra_words[0] = seed;
    ra_words[1] = seed;
    for (int i = 0; i < (WarmupRounds & 'h7F); i++) begin
      void'(rotadd_step());
    end
  endfunction

  function automatic logic [DataW-1:0] predict_random();
    case (alg_q)
      ALG_SPLITMIX: return splitmix_step();
      ALG_XOSHIRO:  return xoshiro_step();
      ALG_ROTADD:   return rotadd_step();
      default:      return '0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q      = AlgResetVal;
      sm_counter = '0;
      for (int i = 0; i < XoDepth; i++) begin
        xo_words[i] = '0;
      end
      ra_words[0] = '0;
      ra_words[1] = '0;
      expected_randoms.delete();
      mismatches = 0;
      checked    = 0;
      mismatch_count_o  <= 0;
      expected_left_o   <= 0;
      results_checked_o <= 0;
    end else begin
      // A result never leaves at the edge that accepts its item, so the oldest
      // expectation is taken before this edge's item is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (expected_randoms.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result random_value=%h", $time, random_value_i);
          end
          mismatches++;
        end else begin
          oldest_expected = expected_randoms.pop_front();
          checked++;
          if (random_value_i !== oldest_expected) begin
            if (mismatches < 10) begin
              $display("%0t: random_value mismatch: expected %h, got %h",
                       $time, oldest_expected, random_value_i);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        alg_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_SEED) begin
          reseed_all(seed_value_i);
        end else begin
          expected_randoms.push_back(predict_random());
        end
      end
      mismatch_count_o  <= mismatches;
      expected_left_o   <= expected_randoms.size();
      results_checked_o <= checked;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// -----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the seeded multi-algorithm PRNG unit: directed
// seeds and draws, then random phases over every selector code and idling mix.
// -----------------------------------------------------------------------------
module tb_top;

  import smprng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The warm-up count is shared by the block and the checker so that both
  // agree on how far a seed runs the rotate-add generator.
  localparam int unsigned WarmupRounds = WarmupRoundsDef;
  // The settle time before a register write covers the time for which a seed
  // holds the input off, with some margin.
  localparam int SettleCycles  = WarmupRounds + 38 + 16;
  localparam int WatchdogLimit = 4000;
  localparam int NumPhases     = 16;
  // Selector code that picks no generator.
  localparam logic [AlgW-1:0] AlgUnused = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [AlgW-1:0]  cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             opcode_i;
  logic [DataW-1:0] seed_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [DataW-1:0] random_value_o;

  int mismatch_count;
  int expected_left;
  int results_checked;

  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int items_sent;
  int seeds_sent;

  seeded_multi_algorithm_prng_unit #(
    .WARMUP_ROUNDS(WarmupRounds)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .seed_value_i  (seed_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_value_o(random_value_o)
  );

  smprng_checker #(
    .WarmupRounds(WarmupRounds)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .opcode_i         (opcode_i),
    .seed_value_i     (seed_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .random_value_i   (random_value_o),
    .mismatch_count_o (mismatch_count),
    .expected_left_o  (expected_left),
    .results_checked_o(results_checked)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The receiver stalls at random with the current phase's probability. The
  // stall changes on the falling edge, like every other input.
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // The watchdog counts cycles in which nothing moves on either channel or
  // the register port. The longest quiet stretch of a correct run is a seed
  // followed by the settle time before a write, far below the limit.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results still expected", $time, expected_left);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one item, after an optional random gap, and returns on the
  // falling edge after it was accepted. Valid is left high so that the next
  // item can follow back to back; whoever stops sending lowers it.
  task automatic drive_item(input logic op, input logic [DataW-1:0] seed);
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    items_sent++;
    if (op == OP_SEED) begin
      seeds_sent++;
    end
    @(negedge clk_i);
  endtask

  // Writes the select register once the block is idle: every expected
  // result has been taken, and a seed still warming up has had time to end.
  task automatic write_select(input logic [AlgW-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_left != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [AlgW-1:0]  alg;
    logic [DataW-1:0] seed;
    int               count;
    int               mode;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_NEXT;
    seed_value_i = '0;
    out_stall_i  = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    seeds_sent   = 0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Draws before any seed: xoshiro256++ (the reset selection) stays at
    // zero, while SplitMix64 and the rotate-add generator run from zero.
    // The ignored seed field carries all ones in some of these draws.
    drive_item(OP_NEXT, '1);
    drive_item(OP_NEXT, '1);
    write_select(ALG_SPLITMIX);
    drive_item(OP_NEXT, '0);
    drive_item(OP_NEXT, '1);
    write_select(ALG_ROTADD);
    drive_item(OP_NEXT, '0);
    drive_item(OP_NEXT, '0);
    // The unused selector code returns zero and advances nothing.
    write_select(AlgUnused);
    drive_item(OP_NEXT, '1);

    // Seeds at the extremes of the field, each followed by draws, the second by
    // draws from every generator. The rotate-add draw after the unused code shows
    // that the unused code left that generator alone.
    drive_item(OP_SEED, '0);
    write_select(ALG_XOSHIRO);
    drive_item(OP_NEXT, '0);
    drive_item(OP_NEXT, '0);
    drive_item(OP_SEED, '1);
    drive_item(OP_NEXT, '0);
    write_select(ALG_SPLITMIX);
    drive_item(OP_NEXT, '0);
    write_select(ALG_ROTADD);
    drive_item(OP_NEXT, '0);
    write_select(AlgUnused);
    drive_item(OP_NEXT, '0);
    write_select(ALG_ROTADD);
    drive_item(OP_NEXT, '0);

    // Two seeds back to back: only the second must count.
    drive_item(OP_SEED, {1'b1, {(DataW-1){1'b0}}});
    drive_item(OP_SEED, {{(DataW-1){1'b0}}, 1'b1});
    drive_item(OP_NEXT, '0);
    drive_item(OP_NEXT, '0);

    // Random phases. Every selector code meets every idling mix. Most items
    // are draws with random payload, with a seed now and then so that the
    // generators restart from fresh states; the unused code gets short runs.
    for (int ph = 0; ph < NumPhases; ph++) begin
      alg  = AlgW'(ph % 4);
      mode = (ph / 4) % 4;
      write_select(alg);
      case (mode)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct  = 28;
          stall_pct = 28;
        end
      endcase
      count = (alg == AlgUnused) ? 20 : 75;
      for (int n = 0; n < count; n++) begin
        seed = {$urandom, $urandom};
        if ($urandom_range(99) < 8) begin
          // Now and then a seed at one of the extremes.
          if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
              0:       seed = '0;
              1:       seed = '1;
              2:       seed = {{(DataW-1){1'b0}}, 1'b1};
              default: seed = {1'b1, {(DataW-1){1'b0}}};
            endcase
          end
          drive_item(OP_SEED, seed);
        end else begin
          drive_item(OP_NEXT, seed);
        end
      end
    end

    // Drain: wait for every expected result, then a while longer so that a
    // stray extra result would still be seen.
    in_valid_i <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (expected_left != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);

    $display("Sent %0d items (%0d seeds) over all four selector codes and four idling mixes;",
             items_sent, seeds_sent);
    $display("checked %0d returned numbers, %0d mismatches.", results_checked, mismatch_count);
    if ((mismatch_count == 0) && (expected_left == 0)) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
